/* rtl/rpn_stack_calculator_defines.svh */
// Assertion macros shared by the calculator RTL.
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define RPN_ASSERT_NOW(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("rpn assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RPN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rpn assertion failed");

`endif

/* rtl/rpn_pkg.sv */
// Types, codes and widths of the RPN stack calculator.
`default_nettype none

package rpn_pkg;

   localparam int DataWidth         = 32;
   localparam int StackDepthDefault = 64;
   localparam int OpWidth           = 4;
   localparam int StatusWidth       = 2;
   localparam int LevelWidth        = 7;
   // rsp tdata: top_value then stack_level, padded to whole bytes
   localparam int RspDataWidth      = ((DataWidth + LevelWidth + 7) / 8) * 8;

   typedef logic signed [DataWidth-1:0] word_type;
   typedef logic [DataWidth-1:0]        uword_type;

   // request codes
   localparam logic [OpWidth-1:0] OP_PUSH  = 4'd0;
   localparam logic [OpWidth-1:0] OP_ADD   = 4'd1;
   localparam logic [OpWidth-1:0] OP_SUB   = 4'd2;
   localparam logic [OpWidth-1:0] OP_MUL   = 4'd3;
   localparam logic [OpWidth-1:0] OP_DIV   = 4'd4;
   localparam logic [OpWidth-1:0] OP_GT    = 4'd5;
   localparam logic [OpWidth-1:0] OP_LT    = 4'd6;
   localparam logic [OpWidth-1:0] OP_GE    = 4'd7;
   localparam logic [OpWidth-1:0] OP_LE    = 4'd8;
   localparam logic [OpWidth-1:0] OP_EQ    = 4'd9;
   localparam logic [OpWidth-1:0] OP_DROP  = 4'd10;
   localparam logic [OpWidth-1:0] OP_SHOW  = 4'd11;

   // status codes
   localparam logic [StatusWidth-1:0] ST_OK    = 2'd0;
   localparam logic [StatusWidth-1:0] ST_UNDER = 2'd1;
   localparam logic [StatusWidth-1:0] ST_OVER  = 2'd2;
   localparam logic [StatusWidth-1:0] ST_DIVZ  = 2'd3;

   // stack update applied when a result is committed
   localparam int ActWidth = 3;
   localparam logic [ActWidth-1:0] ACT_NONE    = 3'd0;
   localparam logic [ActWidth-1:0] ACT_PUSH    = 3'd1;
   localparam logic [ActWidth-1:0] ACT_REPLACE = 3'd2;
   localparam logic [ActWidth-1:0] ACT_DROP    = 3'd3;
   localparam logic [ActWidth-1:0] ACT_PRINT   = 3'd4;

   // per-cell move: take from the cell above (push side) or below (pop side)
   typedef struct packed {
      logic take_up;
      logic take_down;
   } rpn_shift_type;

endpackage

`default_nettype wire

/* rtl/rpn_cell.sv */
// One stack cell: holds one entry and shifts with its neighbors.
`default_nettype none

module rpn_cell (
   input  wire                   clock,
   input  rpn_pkg::rpn_shift_type shift,
   input  rpn_pkg::word_type     up_data,    // entry of the cell nearer the top
   input  rpn_pkg::word_type     down_data,  // entry of the cell deeper down
   output rpn_pkg::word_type     data
);
   import rpn_pkg::*;

   word_type data_ff;
   word_type data_in;

   // push moves entries down, pop moves them up
   always_comb begin
      priority if (shift.take_up) begin
         data_in = up_data;
      end else if (shift.take_down) begin
         data_in = down_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

/* rtl/rpn_divider.sv */
// Iterative signed divider, one quotient bit per cycle, truncating.
`default_nettype none

module rpn_divider (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  rpn_pkg::word_type dividend,
   input  rpn_pkg::word_type divisor,
   output logic              done,
   output rpn_pkg::word_type quotient
);
   import rpn_pkg::*;

`include "rpn_stack_calculator_defines.svh"

   localparam int StepWidth = $clog2(DataWidth);
   localparam logic [StepWidth-1:0] LastStep = StepWidth'(DataWidth - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [StepWidth-1:0] step_ff, step_in;
   uword_type            rem_ff, rem_in;
   uword_type            quo_ff, quo_in;
   uword_type            dsr_ff, dsr_in;
   logic                 neg_ff, neg_in;

   logic [DataWidth:0]   shifted;
   logic [DataWidth:0]   trial;
   uword_type            dividend_mag;
   uword_type            divisor_mag;

   assign dividend_mag = dividend[DataWidth-1] ? uword_type'(-dividend) : uword_type'(dividend);
   assign divisor_mag  = divisor[DataWidth-1]  ? uword_type'(-divisor)  : uword_type'(divisor);

   // restoring step on magnitudes
   assign shifted = {rem_ff, quo_ff[DataWidth-1]};
   assign trial   = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend_mag;
         dsr_in  = divisor_mag;
         neg_in  = dividend[DataWidth-1] ^ divisor[DataWidth-1];
      end else if (busy_ff) begin
         if (!trial[DataWidth]) begin
            rem_in = trial[DataWidth-1:0];
         end else begin
            rem_in = shifted[DataWidth-1:0];
         end
         quo_in  = {quo_ff[DataWidth-2:0], ~trial[DataWidth]};
         step_in = step_ff + 1'b1;
         if (step_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? word_type'(-quo_ff) : word_type'(quo_ff);

   `RPN_ASSERT_NOW(a_no_start_when_busy, clock, reset, !(start && busy_ff))
   `RPN_ASSERT_NOW(a_done_not_busy, clock, reset, !(done_ff && busy_ff))

endmodule

`default_nettype wire

/* rtl/rpn_stack_calculator.sv */
// Top level of the RPN stack calculator: sequencer, cell chain and divider.
// A request is captured in IDLE, classified in EXEC and committed in DONE; a division
// first waits in DIV for the 32-step divider. A new request is taken only in IDLE,
// after the last commit; a waiting result holds the commit of the next request.
// Reset (synchronous, active high) empties the stack and drops any pending result.
// Stack entries live in a shift chain of cells; the top entry is cell zero.
`default_nettype none

module rpn_stack_calculator #(
   parameter int STACK_DEPTH = rpn_pkg::StackDepthDefault
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // request channel
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [rpn_pkg::DataWidth-1:0]         req_tdata,  // [31:0] push_value
   input  wire  [rpn_pkg::OpWidth-1:0]           req_tuser,  // [3:0] req_type
   // result channel
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [rpn_pkg::RspDataWidth-1:0]      rsp_tdata,  // [31:0] top_value,
                                                             // [38:32] stack_level
   output logic [rpn_pkg::StatusWidth-1:0]       rsp_tuser   // [1:0] status
);
   import rpn_pkg::*;

`include "rpn_stack_calculator_defines.svh"

   localparam int CountWidth = $clog2(STACK_DEPTH + 1);
   localparam logic [CountWidth-1:0] DepthCount = CountWidth'(STACK_DEPTH);
   localparam logic [CountWidth-1:0] TwoCount   = CountWidth'(2);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [OpWidth-1:0]     op_ff, op_in;
   word_type               value_ff, value_in;
   word_type               result_ff, result_in;
   logic [ActWidth-1:0]    action_ff, action_in;
   logic [StatusWidth-1:0] status_ff, status_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   word_type               rsp_top_ff, rsp_top_in;
   logic [StatusWidth-1:0] rsp_status_ff, rsp_status_in;
   logic [LevelWidth-1:0]  rsp_level_ff, rsp_level_in;

   word_type               cell_data [STACK_DEPTH];
   word_type               top_entry;
   word_type               next_entry;
   word_type               new_top;
   rpn_shift_type          head_shift;
   rpn_shift_type          body_shift;

   logic                   commit;
   logic                   div_start;
   logic                   div_done;
   word_type               div_quotient;
   uword_type              product;
   word_type               top_or_zero;

   assign top_entry  = cell_data[0];
   assign next_entry = cell_data[1];
   assign product    = uword_type'(next_entry) * uword_type'(top_entry);
   assign top_or_zero = (count_ff != '0) ? top_entry : '0;

   assign req_tready = (state_ff == S_IDLE);
   assign commit     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   // sequencer: classify in EXEC, wait for the divider, commit in DONE
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      value_in  = value_ff;
      result_in = result_ff;
      action_in = action_ff;
      status_in = status_ff;
      div_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               value_in = word_type'(req_tdata);
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            action_in = ACT_NONE;
            status_in = ST_OK;
            state_in  = S_DONE;
            unique case (op_ff)
               OP_PUSH: begin
                  if (count_ff >= DepthCount) begin
                     status_in = ST_OVER;
                  end else begin
                     action_in = ACT_PUSH;
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE, OP_EQ: begin
                  if (count_ff < TwoCount) begin
                     status_in = ST_UNDER;
                  end else if (op_ff == OP_DIV && top_entry == '0) begin
                     status_in = ST_DIVZ;
                  end else begin
                     action_in = ACT_REPLACE;
                     unique case (op_ff)
                        OP_ADD: result_in = next_entry + top_entry;
                        OP_SUB: result_in = next_entry - top_entry;
                        OP_MUL: result_in = word_type'(product);
                        OP_GT:  result_in = word_type'(next_entry > top_entry);
                        OP_LT:  result_in = word_type'(next_entry < top_entry);
                        OP_GE:  result_in = word_type'(next_entry >= top_entry);
                        OP_LE:  result_in = word_type'(next_entry <= top_entry);
                        OP_EQ:  result_in = word_type'(next_entry == top_entry);
                        default: begin
                           // division: hand off to the iterative unit
                           div_start = 1'b1;
                           state_in  = S_DIV;
                        end
                     endcase
                  end
               end
               OP_DROP: begin
                  if (count_ff == '0) begin
                     status_in = ST_UNDER;
                  end else begin
                     action_in = ACT_DROP;
                  end
               end
               OP_SHOW: begin
                  if (count_ff == '0) begin
                     status_in = ST_UNDER;
                  end else begin
                     action_in = ACT_PRINT;
                  end
               end
               default: begin
                  // unused request codes leave the stack alone but still return a result
                  action_in = ACT_NONE;
               end
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               result_in = div_quotient;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // stack update and result register on commit
   always_comb begin
      count_in      = count_ff;
      head_shift    = '0;
      body_shift    = '0;
      rsp_top_in    = rsp_top_ff;
      rsp_status_in = rsp_status_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      if (commit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         unique case (action_ff)
            ACT_PUSH: begin
               count_in             = count_ff + 1'b1;
               head_shift.take_up   = 1'b1;
               body_shift.take_up   = 1'b1;
               rsp_top_in           = value_ff;
            end
            ACT_REPLACE: begin
               count_in             = count_ff - 1'b1;
               head_shift.take_up   = 1'b1;
               body_shift.take_down = 1'b1;
               rsp_top_in           = result_ff;
            end
            ACT_DROP: begin
               count_in             = count_ff - 1'b1;
               head_shift.take_down = 1'b1;
               body_shift.take_down = 1'b1;
               rsp_top_in           = (count_ff >= TwoCount) ? next_entry : '0;
            end
            ACT_PRINT: begin
               count_in             = count_ff - 1'b1;
               head_shift.take_down = 1'b1;
               body_shift.take_down = 1'b1;
               rsp_top_in           = top_entry;
            end
            default: begin
               rsp_top_in = top_or_zero;
            end
         endcase
         rsp_level_in = LevelWidth'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      value_ff      <= value_in;
      result_ff     <= result_in;
      action_ff     <= action_in;
      status_ff     <= status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_status_ff <= rsp_status_in;
      rsp_level_ff  <= rsp_level_in;
   end

   // cell chain: cell zero takes the new top, the last cell sees zeros below
   assign new_top = (action_ff == ACT_PUSH) ? value_ff : result_ff;

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      word_type up_data;
      word_type down_data;
      if (i == 0) begin : g_head
         assign up_data = new_top;
      end else begin : g_body
         assign up_data = cell_data[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_tail
         assign down_data = '0;
      end else begin : g_link
         assign down_data = cell_data[i+1];
      end
      rpn_cell u_cell (
         .clock     (clock),
         .shift     ((i == 0) ? head_shift : body_shift),
         .up_data   (up_data),
         .down_data (down_data),
         .data      (cell_data[i])
      );
   end

   rpn_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (next_entry),
      .divisor  (top_entry),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth - DataWidth - LevelWidth){1'b0}},
                        rsp_level_ff, rsp_top_ff};
   assign rsp_tuser  = rsp_status_ff;

   `RPN_ASSERT_NOW(a_count_in_range, clock, reset, count_ff <= DepthCount)
   `RPN_ASSERT_NOW(a_div_done_in_wait, clock, reset, !div_done || state_ff == S_DIV)
   `RPN_ASSERT_NEXT(a_push_grows, clock, reset, commit && action_ff == ACT_PUSH,
                    count_ff == $past(count_ff) + 1'b1)
   `RPN_ASSERT_NEXT(a_commit_shows, clock, reset, commit,
                    rsp_valid_ff && state_ff == S_IDLE)

endmodule

`default_nettype wire
